// ----- design/scancode_line_decoder_core_macros.svh -----
// assertion helpers shared by the checker
`ifndef SCANCODE_LINE_DECODER_CORE_MACROS_SVH
`define SCANCODE_LINE_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define SCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scd assertion failed");

// next-cycle implication
`define SCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scd assertion failed");

`endif

// ----- design/scd_pkg.sv -----
`timescale 1ns / 1ps

package scd_pkg;

	localparam int LINE_CAPACITY_DEF = 128;
	localparam int ROM_SIZE = 58;

	typedef enum logic [2:0] {
		KIND_NONE     = 3'd0,
		KIND_CHAR     = 3'd1,
		KIND_LINE_END = 3'd2,
		KIND_BACKSP   = 3'd3,
		KIND_CLEAR    = 3'd4
	} scd_kind_t;

	typedef enum logic [2:0] {
		ROM_STD       = 3'd0,
		ROM_SHIFT     = 3'd1,
		ROM_CAPS      = 3'd2,
		ROM_CAPSSHIFT = 3'd3,
		ROM_CTRL      = 3'd4,
		ROM_ALT       = 3'd5
	} scd_rom_t;

	typedef struct packed {
		scd_kind_t  event_kind;
		logic [7:0] char_code;
		logic [7:0] position;
		logic [3:0] modifier_bits;
	} scd_result_t;

	typedef struct packed {
		logic [3:0] mods;
		logic [7:0] len;
	} scd_state_t;

	localparam logic [7:0] SC_CAPS       = 8'h3A;
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
	localparam logic [7:0] SC_CTRL       = 8'h1D;
	localparam logic [7:0] SC_CTRL_REL   = 8'h9D;
	localparam logic [7:0] SC_ALT        = 8'h38;
	localparam logic [7:0] SC_ALT_REL    = 8'hB8;
	localparam logic [7:0] SC_ENTER      = 8'h1C;
	localparam logic [7:0] SC_BACKSPACE  = 8'h0E;
	localparam logic [7:0] SC_KEY_L      = 8'h26;
	localparam logic [7:0] SC_PRINT_LO   = 8'h02;
	localparam logic [7:0] SC_PRINT_HI   = 8'h39;

	localparam logic [3:0] MOD_SHIFT = 4'h1;
	localparam logic [3:0] MOD_CAPS  = 4'h2;
	localparam logic [3:0] MOD_CTRL  = 4'h4;
	localparam logic [3:0] MOD_ALT   = 4'h8;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam logic [7:0] KEYS_STD [ROM_SIZE] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
		8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D,
		8'h0A, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60,
		8'h00,
		8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00,
		8'h2A, 8'h00, 8'h20
	};

	localparam logic [7:0] KEYS_SHIFT [ROM_SIZE] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
		8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D,
		8'h0A, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E,
		8'h00,
		8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00,
		8'h2A, 8'h00, 8'h20
	};

	localparam logic [7:0] KEYS_CAPS [ROM_SIZE] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
		8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h5B, 8'h5D,
		8'h0A, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B, 8'h27, 8'h60,
		8'h00,
		8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00,
		8'h2A, 8'h00, 8'h20
	};

	localparam logic [7:0] KEYS_CAPSSHIFT [ROM_SIZE] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
		8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h7B, 8'h7D,
		8'h0A, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3A, 8'h22, 8'h7E,
		8'h00,
		8'h7C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h3C, 8'h3E, 8'h3F, 8'h00,
		8'h2A, 8'h00, 8'h20
	};

	localparam logic [7:0] KEYS_CTRL [ROM_SIZE] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h1E, 8'h26, 8'h2A, 8'h28, 8'h29,
		8'h1F, 8'h2B, 8'h08, 8'h09,
		8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h19, 8'h15, 8'h09, 8'h0F, 8'h10, 8'h1B, 8'h1D,
		8'h0A, 8'h00,
		8'h01, 8'h13, 8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h3A, 8'h22, 8'h7E,
		8'h00,
		8'h1C, 8'h1A, 8'h18, 8'h03, 8'h16, 8'h02, 8'h0E, 8'h0D, 8'h3C, 8'h3E, 8'h3F, 8'h00,
		8'h2A, 8'h00, 8'h20
	};

	localparam logic [7:0] KEYS_ALT [ROM_SIZE] = '{
		8'h00, 8'h1B, 8'h78, 8'h79, 8'h7A, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h7F, 8'h80, 8'h81,
		8'h82, 8'h83, 8'h0E, 8'hA5,
		8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B,
		8'h1C, 8'h00,
		8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
		8'h00,
		8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h00,
		8'h2A, 8'h00, 8'h20
	};

	function automatic logic [7:0] key_lookup(scd_rom_t sel, logic [5:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		case (sel)
			ROM_STD:       ch = KEYS_STD[idx];
			ROM_SHIFT:     ch = KEYS_SHIFT[idx];
			ROM_CAPS:      ch = KEYS_CAPS[idx];
			ROM_CAPSSHIFT: ch = KEYS_CAPSSHIFT[idx];
			ROM_CTRL:      ch = KEYS_CTRL[idx];
			ROM_ALT:       ch = KEYS_ALT[idx];
			default:       ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- design/scd_decode.sv -----
`timescale 1ns / 1ps

module scd_decode #(
	parameter int LINE_CAPACITY = scd_pkg::LINE_CAPACITY_DEF
) (
	input  logic [7:0]          code,
	input  scd_pkg::scd_state_t cur,
	output scd_pkg::scd_state_t nxt,
	output scd_pkg::scd_result_t res
);
	import scd_pkg::*;

	localparam logic [7:0] CAP = 8'(LINE_CAPACITY);

	logic      full;
	logic      rom_ok;
	scd_rom_t  rom_sel;
	logic [7:0] len_inc;

	assign full    = (cur.len >= CAP);
	assign len_inc = cur.len + 8'd1;

	always_comb begin
		rom_ok  = 1'b1;
		rom_sel = ROM_STD;
		case (cur.mods)
			4'h0:    rom_sel = ROM_STD;
			4'h1:    rom_sel = ROM_SHIFT;
			4'h2:    rom_sel = ROM_CAPS;
			4'h3:    rom_sel = ROM_CAPSSHIFT;
			4'h4:    rom_sel = ROM_CTRL;
			4'h8:    rom_sel = ROM_ALT;
			default: rom_ok = 1'b0;
		endcase
	end

	always_comb begin
		nxt        = cur;
		res.event_kind = KIND_NONE;
		res.char_code  = 8'h00;
		res.position   = 8'h00;
		if (!(full && code != SC_BACKSPACE)) begin
			case (code)
				SC_CAPS:                      nxt.mods = cur.mods ^ MOD_CAPS;
				SC_LSHIFT, SC_RSHIFT:         nxt.mods = cur.mods | MOD_SHIFT;
				SC_LSHIFT_REL, SC_RSHIFT_REL: nxt.mods = cur.mods & ~MOD_SHIFT;
				SC_CTRL:                      nxt.mods = cur.mods | MOD_CTRL;
				SC_CTRL_REL:                  nxt.mods = cur.mods & ~MOD_CTRL;
				SC_ALT:                       nxt.mods = cur.mods | MOD_ALT;
				SC_ALT_REL:                   nxt.mods = cur.mods & ~MOD_ALT;
				SC_ENTER: begin
					res.event_kind = KIND_LINE_END;
					res.char_code  = CH_NEWLINE;
					res.position   = cur.len;
					nxt.len        = 8'h00;
				end
				SC_BACKSPACE: begin
					if (cur.len != 8'h00) begin
						nxt.len        = cur.len - 8'd1;
						res.event_kind = KIND_BACKSP;
						res.position   = cur.len - 8'd1;
					end
				end
				default: begin
					if (code >= SC_PRINT_LO && code <= SC_PRINT_HI && rom_ok) begin
						res.event_kind = KIND_CHAR;
						res.char_code  = key_lookup(rom_sel, code[5:0]);
						res.position   = cur.len;
						nxt.len        = len_inc;
					end
					// ctrl-l clears after any append
					if ((cur.mods & MOD_CTRL) != 4'h0 && code == SC_KEY_L) begin
						res.event_kind = KIND_CLEAR;
						res.char_code  = 8'h00;
						res.position   = nxt.len;
						nxt.len        = 8'h00;
					end
				end
			endcase
		end
		res.modifier_bits = nxt.mods;
	end

endmodule

// ----- design/scancode_line_decoder_core.sv -----
`timescale 1ns / 1ps
// set-1 scancode line decoder
// input channel: in_valid / in_ready carry one raw scancode byte (scan_code) per
//   transaction; bit 7 set marks a key release
// output channel: out_valid / out_ready carry exactly one event per input
//   transaction: event_kind, char_code, position and modifier_bits
// an accepted transaction passes through the input register, then the result
//   register, before it shows on the output
// throughput: one transaction per cycle while out_ready is high; the decode, key
//   table lookup and modifier / line length update sit between the two registers
// when the receiver stalls, the result register holds its event and the input
//   register still takes one more transaction; in_ready drops only when both are
//   full and out_ready is low
// reset (arst_n low) empties both registers, clears the modifier set and sets the
//   line length to zero; the block can accept a transaction once arst_n rises
// LINE_CAPACITY sets the line length at which all codes but backspace are ignored
module scancode_line_decoder_core #(
	parameter int LINE_CAPACITY = scd_pkg::LINE_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_kind,
	output logic [7:0] char_code,
	output logic [7:0] position,
	output logic [3:0] modifier_bits
);
	import scd_pkg::*;

	logic        valid_s1;
	logic [7:0]  code_s1;
	logic        out_valid_q;
	scd_result_t out_q;
	scd_state_t  state_q;
	scd_state_t  state_nxt;
	scd_result_t res;
	logic        advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	scd_decode #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_decode (
		.code(code_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= scan_code;
		end
		if (advance) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = out_q.event_kind;
	assign char_code     = out_q.char_code;
	assign position      = out_q.position;
	assign modifier_bits = out_q.modifier_bits;

endmodule

// ----- design/scd_checker.sv -----
`timescale 1ns / 1ps
`include "scancode_line_decoder_core_macros.svh"

module scd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] event_kind,
	input logic [7:0] char_code,
	input logic [7:0] position,
	input logic [3:0] modifier_bits
);
	import scd_pkg::*;

	// stalled result holds
	`SCD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(event_kind) && $stable(char_code) && $stable(position) && $stable(modifier_bits))

	// empty output side never blocks input
	`SCD_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// line end always carries a newline
	`SCD_ASSERT_IMP(a_line_end_char, clk, arst_n, out_valid && event_kind == KIND_LINE_END, char_code == CH_NEWLINE)

	// only appends and line ends carry a character
	`SCD_ASSERT_IMP(a_char_zero, clk, arst_n, out_valid && (event_kind == KIND_NONE || event_kind == KIND_BACKSP || event_kind == KIND_CLEAR), char_code == 8'h00)

	// a no-op event reports slot zero
	`SCD_ASSERT_IMP(a_none_pos, clk, arst_n, out_valid && event_kind == KIND_NONE, position == 8'h00)

endmodule

bind scancode_line_decoder_core scd_checker u_scd_checker (.*);

// ----- test/scancode_line_decoder_core_tb.sv -----
`timescale 1ns / 1ps

module scancode_line_decoder_core_tb;
	import scd_pkg::*;

	localparam int LINE_CAP = 128;
	localparam int RANDOM_ITEMS = 900;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [3:0] MODS_NONE = 4'h0;
	localparam int TX_SIDE = 0;
	localparam int RX_SIDE = 1;

	typedef struct packed {
		logic [7:0] code;
		logic       drain;
	} key_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] scan_code = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] event_kind;
	logic [7:0] char_code;
	logic [7:0] position;
	logic [3:0] modifier_bits;

	key_item_t   key_fifo [$];
	scd_result_t expected_events [$];
	scd_result_t want;
	key_item_t   next_key;
	logic [7:0]  keymap [6][58];
	logic [3:0]  mods_now = MODS_NONE;
	logic [7:0]  line_len = 8'd0;
	bit          calm [2];
	int          tx_gap = 0;
	int          rx_stall = 0;
	int          queued = 0;
	int          fail_count = 0;
	int          idle_cycles = 0;

	scancode_line_decoder_core #(
		.LINE_CAPACITY(LINE_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.scan_code(scan_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.char_code(char_code),
		.position(position),
		.modifier_bits(modifier_bits)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic fill_rom(input int rom, input string digits, input string top,
			input string home, input string bottom);
		for (int i = 0; i < 58; i++)
			keymap[rom][i] = 8'h00;
		keymap[rom][1] = 8'h1B;
		keymap[rom][14] = 8'h08;
		keymap[rom][15] = 8'h09;
		keymap[rom][28] = 8'h0A;
		keymap[rom][55] = 8'h2A;
		keymap[rom][57] = 8'h20;
		for (int i = 0; i < 12; i++) begin
			keymap[rom][2 + i] = digits[i];
			keymap[rom][16 + i] = top[i];
			keymap[rom][30 + i] = home[i];
		end
		for (int i = 0; i < 11; i++)
			keymap[rom][43 + i] = bottom[i];
	endtask

	task automatic build_keymaps();
		logic [7:0] c;
		fill_rom(ROM_STD, "1234567890-=", "qwertyuiop[]", "asdfghjkl;'?", "\\zxcvbnm,./");
		fill_rom(ROM_SHIFT, "!@#$%^&*()_+", "QWERTYUIOP{}", "ASDFGHJKL:\"~", "|ZXCVBNM<>?");
		fill_rom(ROM_CAPS, "1234567890-=", "QWERTYUIOP[]", "ASDFGHJKL;'?", "\\ZXCVBNM,./");
		fill_rom(ROM_CAPSSHIFT, "!@#$%^&*()_+", "qwertyuiop{}", "asdfghjkl:\"~",
			"|zxcvbnm<>?");
		// backtick
		keymap[ROM_STD][41] = 8'h60;
		keymap[ROM_CAPS][41] = 8'h60;
		// ctrl map: shifted map with letters and a few symbols folded to control codes
		for (int i = 0; i < 58; i++) begin
			c = keymap[ROM_SHIFT][i];
			if ((c >= 8'h41 && c <= 8'h5A) || c == 8'h5E || c == 8'h5F ||
					(c >= 8'h7B && c <= 8'h7D))
				c = c & 8'h1F;
			keymap[ROM_CTRL][i] = c;
		end
		for (int i = 0; i < 58; i++) begin
			if (i >= 2 && i <= 13)
				keymap[ROM_ALT][i] = 8'(118 + i);
			else if (i >= 16 && i <= 53 && i != 29 && i != 42)
				keymap[ROM_ALT][i] = 8'(i);
			else
				keymap[ROM_ALT][i] = 8'h00;
		end
		keymap[ROM_ALT][1] = 8'h1B;
		keymap[ROM_ALT][14] = 8'h0E;
		keymap[ROM_ALT][15] = 8'hA5;
		keymap[ROM_ALT][55] = 8'h2A;
		keymap[ROM_ALT][57] = 8'h20;
	endtask

	function automatic scd_result_t decode_key(input logic [7:0] code);
		scd_result_t r;
		int rom;
		r.event_kind = KIND_NONE;
		r.char_code = 8'h00;
		r.position = 8'h00;
		if (line_len < LINE_CAP || code == SC_BACKSPACE) begin
			case (code)
				SC_CAPS: mods_now = mods_now ^ MOD_CAPS;
				SC_LSHIFT, SC_RSHIFT: mods_now = mods_now | MOD_SHIFT;
				SC_LSHIFT_REL, SC_RSHIFT_REL: mods_now = mods_now & ~MOD_SHIFT;
				SC_CTRL: mods_now = mods_now | MOD_CTRL;
				SC_CTRL_REL: mods_now = mods_now & ~MOD_CTRL;
				SC_ALT: mods_now = mods_now | MOD_ALT;
				SC_ALT_REL: mods_now = mods_now & ~MOD_ALT;
				SC_ENTER: begin
					r.event_kind = KIND_LINE_END;
					r.char_code = CH_NEWLINE;
					r.position = line_len;
					line_len = 8'd0;
				end
				SC_BACKSPACE: begin
					if (line_len != 0) begin
						line_len = line_len - 8'd1;
						r.event_kind = KIND_BACKSP;
						r.position = line_len;
					end
				end
				default: begin
					if (code >= SC_PRINT_LO && code <= SC_PRINT_HI) begin
						case (mods_now)
							MODS_NONE: rom = ROM_STD;
							MOD_SHIFT: rom = ROM_SHIFT;
							MOD_CAPS: rom = ROM_CAPS;
							MOD_CAPS | MOD_SHIFT: rom = ROM_CAPSSHIFT;
							MOD_CTRL: rom = ROM_CTRL;
							MOD_ALT: rom = ROM_ALT;
							default: rom = -1;
						endcase
						if (rom >= 0 && line_len < LINE_CAP) begin
							r.event_kind = KIND_CHAR;
							r.char_code = keymap[rom][code];
							r.position = line_len;
							line_len = line_len + 8'd1;
						end
					end
					// ctrl-L clears, even right after appending the control code
					if ((mods_now & MOD_CTRL) != 0 && code == SC_KEY_L) begin
						r.event_kind = KIND_CLEAR;
						r.char_code = 8'h00;
						r.position = line_len;
						line_len = 8'd0;
					end
				end
			endcase
		end
		r.modifier_bits = mods_now;
		return r;
	endfunction

	function automatic int idle_len(input int side);
		int roll;
		if ($urandom_range(0, 63) == 0)
			calm[side] = !calm[side];
		roll = $urandom_range(0, 99);
		if (calm[side] || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] random_modifier();
		case ($urandom_range(0, 8))
			0: return SC_LSHIFT;
			1: return SC_RSHIFT;
			2: return SC_LSHIFT_REL;
			3: return SC_RSHIFT_REL;
			4: return SC_CAPS;
			5: return SC_CTRL;
			6: return SC_CTRL_REL;
			7: return SC_ALT;
			default: return SC_ALT_REL;
		endcase
	endfunction

	function automatic logic [7:0] any_key();
		return 8'($urandom_range(SC_PRINT_LO, SC_PRINT_HI));
	endfunction

	// a key that appends whenever the line has room and no odd modifier is held
	function automatic logic [7:0] plain_key();
		logic [7:0] c;
		c = any_key();
		while (c == SC_BACKSPACE || c == SC_ENTER || c == SC_LSHIFT || c == SC_RSHIFT ||
				c == SC_CTRL || c == SC_ALT)
			c = any_key();
		return c;
	endfunction

	task automatic push_key(input logic [7:0] code);
		key_fifo.push_back('{code: code, drain: 1'b0});
		queued++;
	endtask

	task automatic push_drain();
		key_fifo.push_back('{code: 8'h00, drain: 1'b1});
	endtask

	task automatic fill_line();
		int extra;
		push_key(SC_LSHIFT_REL);
		push_key(SC_RSHIFT_REL);
		push_key(SC_CTRL_REL);
		push_key(SC_ALT_REL);
		push_key(SC_ENTER);
		for (int i = 0; i < LINE_CAP; i++)
			push_key(plain_key());
		extra = $urandom_range(3, 10);
		for (int i = 0; i < extra; i++)
			push_key(8'($urandom_range(0, 255)));
		push_key(SC_BACKSPACE);
		push_key(plain_key());
		push_key(SC_ENTER);
		push_key(SC_BACKSPACE);
		push_key(SC_BACKSPACE);
		push_key(SC_ENTER);
	endtask

	task automatic type_burst();
		int n;
		int roll;
		n = $urandom_range(1, 20);
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 85)
				push_key(any_key());
			else if (roll < 95)
				push_key(SC_BACKSPACE);
			else
				push_key(random_modifier());
		end
	endtask

	task automatic chord();
		bit sh;
		bit ct;
		bit al;
		int n;
		sh = $urandom_range(0, 1);
		ct = $urandom_range(0, 1);
		al = $urandom_range(0, 1);
		n = $urandom_range(1, 6);
		if ($urandom_range(0, 3) == 0)
			push_key(SC_CAPS);
		if (sh)
			push_key($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT);
		if (ct)
			push_key(SC_CTRL);
		if (al)
			push_key(SC_ALT);
		for (int i = 0; i < n; i++)
			push_key($urandom_range(0, 9) < 4 ? SC_KEY_L : any_key());
		if (sh && $urandom_range(0, 9) != 0)
			push_key($urandom_range(0, 1) ? SC_LSHIFT_REL : SC_RSHIFT_REL);
		if (ct && $urandom_range(0, 9) != 0)
			push_key(SC_CTRL_REL);
		if (al && $urandom_range(0, 9) != 0)
			push_key(SC_ALT_REL);
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_val,
			input logic [7:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
				got_val);
			fail_count++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			scan_code <= 8'h00;
		end else begin
			if (in_valid && in_ready)
				expected_events.push_back(decode_key(scan_code));
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (key_fifo.size() != 0 && key_fifo[0].drain) begin
					in_valid <= 1'b0;
					if (expected_events.size() == 0)
						next_key = key_fifo.pop_front();
				end else if (key_fifo.size() != 0) begin
					next_key = key_fifo.pop_front();
					in_valid <= 1'b1;
					scan_code <= next_key.code;
					tx_gap = idle_len(TX_SIDE);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected transaction: expected none, %s %0d %0d %0d %0d",
						$time, "actual kind/char/pos/mods", event_kind, char_code,
						position, modifier_bits);
					fail_count++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_kind", 8'(want.event_kind), 8'(event_kind));
					check_field("char_code", want.char_code, char_code);
					check_field("position", want.position, position);
					check_field("modifier_bits", 8'(want.modifier_bits), 8'(modifier_bits));
				end
				rx_stall = idle_len(RX_SIDE);
			end
			if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		build_keymaps();

		// directed
		push_key(SC_BACKSPACE);
		push_key(8'h00);
		push_key(8'h01);
		push_key(SC_PRINT_LO);
		push_key(SC_PRINT_HI);
		push_key(8'h3B);
		push_key(8'h7F);
		push_key(8'h82);
		push_key(8'hFF);
		push_key(SC_ENTER);
		push_key(SC_LSHIFT);
		push_key(8'h10);
		push_key(SC_CAPS);
		push_key(8'h10);
		push_key(SC_LSHIFT_REL);
		push_key(8'h10);
		push_key(SC_CAPS);
		push_key(SC_CTRL);
		push_key(8'h10);
		push_key(SC_KEY_L);
		push_key(SC_ALT);
		push_key(SC_KEY_L);
		push_key(SC_CTRL_REL);
		push_key(8'h0F);
		push_key(SC_BACKSPACE);
		push_key(SC_ALT_REL);
		push_key(SC_RSHIFT);
		push_key(SC_RSHIFT_REL);
		push_drain();

		fill_line();
		push_drain();
		while (queued < 30 + RANDOM_ITEMS) begin
			case ($urandom_range(0, 99)) inside
				[0:44]: type_burst();
				[45:64]: chord();
				[65:79]: begin
					repeat ($urandom_range(1, 4))
						push_key(random_modifier());
				end
				[80:91]: begin
					if ($urandom_range(0, 1))
						push_key(SC_ENTER);
					else
						repeat ($urandom_range(1, 6))
							push_key(SC_BACKSPACE);
				end
				[92:97]: begin
					repeat ($urandom_range(1, 5))
						push_key(8'($urandom_range(0, 255)));
				end
				default: fill_line();
			endcase
			if ($urandom_range(0, 39) == 0)
				push_drain();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (key_fifo.size() != 0 || in_valid || expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/scd_pkg.sv
design/scd_decode.sv
design/scancode_line_decoder_core.sv
design/scd_checker.sv
test/scancode_line_decoder_core_tb.sv
